>>> src/amt_pkg.sv
`default_nettype none
package amt_pkg;

  localparam int DEF_MAX_RADIUS = 15;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_DATA_W = 11;
  localparam logic [7:0] LEVEL_HIGH = 8'd255;
  localparam logic [7:0] LEVEL_LOW  = 8'd0;

  typedef enum logic [1:0] {
    REG_RADIUS       = 2'd0,
    REG_OFFSET       = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } in_cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic       last_of_frame;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FLUSH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic store;
    logic start;
    logic scan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic emit_after_store;
    logic pending_nz;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> src/amt_ctrl.sv
`default_nettype none
module amt_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_command_i,
  output logic                in_ready_o,
  input  amt_pkg::dp_status_t status_i,
  output amt_pkg::dp_cmd_t    cmd_o
);
  import amt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == CMD_PIXEL) begin
            cmd_o.store = 1'b1;
            if (status_i.emit_after_store) state_d = ST_START;
          end else if (status_i.pending_nz) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

>>> src/amt_datapath.sv
`default_nettype none
module amt_datapath #(
  parameter int MAX_RADIUS = amt_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = amt_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = amt_pkg::DEF_MAX_HEIGHT
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [1:0]                         cfg_index_i,
  input  wire  [amt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  amt_pkg::in_item_t                  in_data_i,
  input  amt_pkg::dp_cmd_t                   cmd_i,
  output amt_pkg::dp_status_t                status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output amt_pkg::out_item_t                 out_data_o
);
  import amt_pkg::*;

  localparam int DEPTH  = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = $clog2(DEPTH + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int DXW    = RW + 1;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QW     = $clog2(MAXDIM + MAX_RADIUS + 1) + 1;
  localparam int DW     = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1) + 1;
  localparam int CW     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SW     = CW + 8;
  localparam int RWW    = RW + WW;

  // configuration
  logic [3:0]            radius_q;
  logic [7:0]            offset_q;
  logic [CFG_DATA_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd1;
      offset_q <= 8'd0;
      width_q  <= CFG_DATA_W'(1024);
      height_q <= CFG_DATA_W'(1024);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_RADIUS:       radius_q <= cfg_data_i[3:0];
        REG_OFFSET:       offset_q <= cfg_data_i[7:0];
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [RW-1:0] er;
  logic [WW-1:0] ew;
  logic [HW-1:0] eh;

  always_comb begin
    if (radius_q == 4'd0) er = RW'(1);
    else if (int'(radius_q) > MAX_RADIUS) er = RW'(MAX_RADIUS);
    else er = RW'(radius_q);
    if (width_q == '0) ew = WW'(1);
    else if (int'(width_q) > MAX_WIDTH) ew = WW'(MAX_WIDTH);
    else ew = WW'(width_q);
    if (height_q == '0) eh = HW'(1);
    else if (int'(height_q) > MAX_HEIGHT) eh = HW'(MAX_HEIGHT);
    else eh = HW'(height_q);
  end

  logic [RWW-1:0] rw;
  assign rw = RWW'(er) * RWW'(ew);

  // line store
  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] ptr_q;
  logic [PW-1:0] pending_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign wr_en   = cmd_i.clear | cmd_i.store;
  assign wr_addr = cmd_i.clear ? clr_addr_q : ptr_q;
  assign wr_data = cmd_i.clear ? 8'd0 : in_data_i.pixel;

  // output position and scan state
  logic [XW-1:0]         ox_q;
  logic [YW-1:0]         oy_q;
  logic signed [DXW-1:0] dx_q, dy_q;
  logic signed [QW-1:0]  qx_q, qy_q;
  logic signed [DW-1:0]  drow_q;
  logic [AW-1:0]         rbase_q;
  logic [SW-1:0]         sum_q;
  logic [CW-1:0]         count_q;
  logic [7:0]            centre_q;
  logic                  acc_q, grab_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [AW-1:0] oslot, col_addr, start_base, next_base;
  logic          take;
  logic          row_end;
  int            t_os, t_sb, t_nb, t_col, t_d;

  always_comb begin
    t_os = int'(ptr_q) - int'(pending_q);
    if (t_os < 0) t_os = t_os + DEPTH;
    oslot = AW'(t_os);
    t_sb = t_os - int'(rw);
    if (t_sb < 0) t_sb = t_sb + DEPTH;
    start_base = AW'(t_sb);
    t_nb = int'(rbase_q) + int'(ew);
    if (t_nb >= DEPTH) t_nb = t_nb - DEPTH;
    next_base = AW'(t_nb);
    t_col = int'(rbase_q) + int'(dx_q);
    if (t_col < 0) t_col = t_col + DEPTH;
    else if (t_col >= DEPTH) t_col = t_col - DEPTH;
    col_addr = AW'(t_col);
    t_d = int'(drow_q) + int'(dx_q);
    take = cmd_i.scan && (qy_q >= 0) && (int'(qy_q) < int'(eh)) &&
           (qx_q >= 0) && (int'(qx_q) < int'(ew)) && (t_d < int'(pending_q));
    row_end = (int'(dx_q) == int'(er));
  end

  assign rd_en   = cmd_i.start | take;
  assign rd_addr = cmd_i.start ? oslot : col_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      ptr_q       <= '0;
      pending_q   <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      acc_q       <= 1'b0;
      grab_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + AW'(1);
      acc_q  <= take;
      grab_q <= cmd_i.start;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.store) begin
        ptr_q     <= (int'(ptr_q) == DEPTH - 1) ? '0 : ptr_q + AW'(1);
        pending_q <= pending_q + PW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        pending_q   <= pending_q - PW'(1);
        if (int'(ox_q) + 1 >= int'(ew)) begin
          ox_q <= '0;
          oy_q <= (int'(oy_q) + 1 >= int'(eh)) ? '0 : oy_q + YW'(1);
        end else begin
          ox_q <= ox_q + XW'(1);
        end
      end
    end
  end

  logic [8+CW:0] prod;
  assign prod = (CW+9)'({1'b0, centre_q} + {1'b0, offset_q}) * (CW+9)'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dx_q    <= -$signed(DXW'(er));
      dy_q    <= -$signed(DXW'(er));
      qx_q    <= QW'(int'(ox_q) - int'(er));
      qy_q    <= QW'(int'(oy_q) - int'(er));
      drow_q  <= DW'(-int'(rw));
      rbase_q <= start_base;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.scan) begin
        if (row_end) begin
          dx_q    <= -$signed(DXW'(er));
          dy_q    <= dy_q + DXW'(1);
          qx_q    <= QW'(int'(ox_q) - int'(er));
          qy_q    <= qy_q + QW'(1);
          drow_q  <= drow_q + DW'(ew);
          rbase_q <= next_base;
        end else begin
          dx_q <= dx_q + DXW'(1);
          qx_q <= qx_q + QW'(1);
        end
      end
      if (acc_q) begin
        sum_q   <= sum_q + SW'(rdata_q);
        count_q <= count_q + CW'(1);
      end
    end
    if (grab_q) centre_q <= rdata_q;
    if (cmd_i.emit) begin
      out_q.level         <= (prod > (CW+9)'(sum_q)) ? LEVEL_HIGH : LEVEL_LOW;
      out_q.last_of_frame <= (int'(oy_q) == int'(eh) - 1) && (int'(ox_q) == int'(ew) - 1);
    end
  end

  assign status_o.clear_last       = (int'(clr_addr_q) == DEPTH - 1);
  assign status_o.emit_after_store = (int'(pending_q) + 1 > int'(rw) + int'(er));
  assign status_o.pending_nz       = (pending_q != '0);
  assign status_o.scan_last        = row_end && (int'(dy_q) == int'(er));
  assign status_o.out_free         = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over one not yet taken");
  a_no_store_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !cmd_i.store)
    else $error("pixel stored during clearing pass");
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pending_q) < DEPTH)
    else $error("pending count beyond line store depth");
  a_acc_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> acc_q)
    else $error("window read not accumulated");
endmodule
`default_nettype wire

>>> src/adaptive_mean_threshold.sv
`default_nettype none
// Adaptive mean threshold over a square box window, pixels in raster order.
// Input channel in_valid_i/in_ready_o carries one request: a pixel, or a
// drain command that flushes one pending result. Output channel
// out_valid_o/out_ready_i returns a binary level and a last-of-frame flag.
// A result leaves radius*width+radius pixels after its own pixel entered.
// A pixel that releases no result leaves the block ready for the next
// request. A request that releases a result holds off further requests
// while the window is summed by at most one read per cycle from the line
// store, visiting every offset. The finished result sits in an output
// register, so the next request is taken while it waits; a stalled receiver
// only holds the block when a further result is ready to be loaded.
// Reset: registers return to radius 1, offset 0, 1024 x 1024 frame, and a
// clearing pass zeroes the line store, (2*MAX_RADIUS+1)*MAX_WIDTH entries,
// during which no request is taken; configuration writes are taken at any
// time but are meant to be made while idle.
module adaptive_mean_threshold #(
  parameter int MAX_RADIUS = amt_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = amt_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = amt_pkg::DEF_MAX_HEIGHT
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [1:0]                     cfg_index_i,
  input  wire  [amt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  amt_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output amt_pkg::out_item_t             out_data_o
);
  import amt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequence the clear, store, window scan and result hand-off
  amt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // hold line store, window accumulator and output register
  amt_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire
